// ----- hdl/vng_pkg.sv -----
package vng_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic [15:0]        corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [9:0]         read_vertex;
    logic               used_fallback;
  } out_item_t;

  localparam int ACC_W = 48;
  localparam int POS_W = 48;
  localparam logic [15:0] UNIT_Q14 = 16'd16384;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_TRI_RD_A,
    S_TRI_RD_B,
    S_TRI_RD_C,
    S_TRI_EDGE,
    S_TRI_MUL,
    S_TRI_CROSS,
    S_TRI_ACC_A,
    S_TRI_ACC_B,
    S_TRI_ACC_C,
    S_TRI_WAIT,
    S_RD_REQ,
    S_RD_WAIT,
    S_RD_ABS,
    S_RD_SHIFT,
    S_RD_SQ,
    S_RD_SUM,
    S_RD_SQRT,
    S_RD_DIV,
    S_RD_OUT
  } state_t;

  // datapath commands
  typedef struct packed {
    logic load_in;
    logic wr_load;
    logic rd_a;
    logic rd_b;
    logic rd_c;
    logic cap_a;
    logic cap_b;
    logic cap_c;
    logic edge_en;
    logic mul_en;
    logic cross_en;
    logic acc_rd;
    logic acc_wr;
    logic rd_acc;
    logic abs_en;
    logic shift_en;
    logic sq_en;
    logic sum_en;
    logic sqrt_start;
    logic div_start;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic tri_ok;
    logic idx_ok;
    logic sqrt_done;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// ----- hdl/vertex_normal_generator_top.sv -----
// Area-weighted vertex normal generator. Load, triangle and read commands
// are handled one at a time. A triangle with a corner out of range is
// skipped; an accepted one takes three position reads and three
// read-modify-write accumulator updates through one-port-read memories. A
// read runs a 32-step square root and a 46-step divider shared by the three
// components. Only read commands produce a result beat. Positions and
// accumulators are not cleared at reset; a vertex must be loaded before use.
module vertex_normal_generator_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vng_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vng_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data
);
  import vng_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [10:0] vertex_count;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  vng_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .cmd(in_data.cmd), .stat(stat), .ctrl(ctrl)
  );

  vng_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .vertex_count(vertex_count),
    .ctrl(ctrl), .stat(stat), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_data)
  );
endmodule

// ----- hdl/vng_ram.sv -----
module vng_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/vng_ctrl.sv -----
module vng_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     cmd,
  input  vng_pkg::stat_t stat,
  output vng_pkg::ctrl_t ctrl
);
  import vng_pkg::*;

  state_t state, state_next;
  logic [1:0] acc_cnt, acc_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      acc_cnt <= '0;
    end else begin
      state   <= state_next;
      acc_cnt <= acc_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    acc_cnt_next = acc_cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(cmd))
            CMD_LOAD: state_next = S_LOAD;
            CMD_TRI:  state_next = S_TRI_RD_A;
            CMD_READ: state_next = S_RD_REQ;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD:     state_next = S_IDLE;
      S_TRI_RD_A: state_next = stat.tri_ok ? S_TRI_RD_B : S_IDLE;
      S_TRI_RD_B: state_next = S_TRI_RD_C;
      S_TRI_RD_C: state_next = S_TRI_EDGE;
      S_TRI_EDGE: state_next = S_TRI_MUL;
      S_TRI_MUL:  state_next = S_TRI_CROSS;
      S_TRI_CROSS: state_next = S_TRI_ACC_A;
      S_TRI_ACC_A: state_next = S_TRI_WAIT;
      S_TRI_ACC_B: state_next = S_TRI_WAIT;
      S_TRI_ACC_C: state_next = S_TRI_WAIT;
      S_TRI_WAIT: begin
        // accumulator read data is back; write it, move to next corner
        acc_cnt_next = acc_cnt + 2'd1;
        if (acc_cnt == 2'd2) begin
          acc_cnt_next = '0;
          state_next   = S_IDLE;
        end else if (acc_cnt == 2'd0) begin
          state_next = S_TRI_ACC_B;
        end else begin
          state_next = S_TRI_ACC_C;
        end
      end
      S_RD_REQ:   state_next = S_RD_WAIT;
      S_RD_WAIT:  state_next = S_RD_ABS;
      S_RD_ABS:   state_next = S_RD_SHIFT;
      S_RD_SHIFT: state_next = S_RD_SQ;
      S_RD_SQ:    state_next = S_RD_SUM;
      S_RD_SUM:   state_next = S_RD_SQRT;
      S_RD_SQRT:  state_next = stat.sqrt_done ? S_RD_DIV : S_RD_SQRT;
      S_RD_DIV:   state_next = stat.div_done ? S_RD_OUT : S_RD_DIV;
      S_RD_OUT:   state_next = stat.out_busy ? S_RD_OUT : S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE:      ctrl.load_in = in_valid;
      S_LOAD:      ctrl.wr_load = 1'b1;
      S_TRI_RD_A:  ctrl.rd_a = 1'b1;
      S_TRI_RD_B:  begin ctrl.rd_b = 1'b1; ctrl.cap_a = 1'b1; end
      S_TRI_RD_C:  begin ctrl.rd_c = 1'b1; ctrl.cap_b = 1'b1; end
      S_TRI_EDGE:  begin ctrl.cap_c = 1'b1; ctrl.edge_en = 1'b1; end
      S_TRI_MUL:   ctrl.mul_en = 1'b1;
      S_TRI_CROSS: ctrl.cross_en = 1'b1;
      S_TRI_ACC_A, S_TRI_ACC_B, S_TRI_ACC_C: ctrl.acc_rd = 1'b1;
      S_TRI_WAIT:  ctrl.acc_wr = 1'b1;
      S_RD_REQ:    ctrl.rd_acc = 1'b1;
      S_RD_ABS:    ctrl.abs_en = 1'b1;
      S_RD_SHIFT:  ctrl.shift_en = 1'b1;
      S_RD_SQ:     ctrl.sq_en = 1'b1;
      S_RD_SUM:    begin ctrl.sum_en = 1'b1; ctrl.sqrt_start = 1'b1; end
      S_RD_SQRT:   ctrl.div_start = stat.sqrt_done;
      S_RD_OUT:    ctrl.out_load = !stat.out_busy;
      default:     ctrl = '0;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_TRI_WAIT) |-> (acc_cnt != 2'd3))
    else $error("corner counter overrun");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (acc_cnt == 2'd0))
    else $error("idle with corner count pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_SUM) |=> (state == S_RD_SQRT))
    else $error("sqrt not entered after sum");
endmodule

// ----- hdl/vng_dp.sv -----
module vng_dp #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  vng_pkg::in_item_t   in_item,
  input  logic [10:0]         vertex_count,
  input  vng_pkg::ctrl_t      ctrl,
  output vng_pkg::stat_t      stat,
  output logic                out_valid,
  input  logic                out_ready,
  output vng_pkg::out_item_t  out_item
);
  import vng_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  in_item_t item;
  logic [AW-1:0] ia, ib, ic, vidx;
  logic [16:0] lim;
  logic tri_ok_r, idx_ok_r;

  // position and accumulator stores
  logic          pos_we;
  logic [AW-1:0] pos_raddr;
  logic [47:0]   pos_rdata;
  logic          acc_we;
  logic [AW-1:0] acc_waddr, acc_raddr;
  logic [3*ACC_W-1:0] acc_wdata, acc_rdata;

  logic signed [15:0] pa [3];
  logic signed [15:0] pb [3];
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [33:0] pr [6];
  logic signed [34:0] nrm [3];
  logic [1:0] corner;
  logic signed [ACC_W-1:0] acc_old [3];
  logic signed [ACC_W-1:0] acc_new [3];

  always_comb begin
    lim = (17'(vertex_count) > 17'(MAX_VERTICES)) ? 17'(MAX_VERTICES) : 17'(vertex_count);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      item     <= in_item;
      tri_ok_r <= (17'(in_item.corner_a) < lim) && (17'(in_item.corner_b) < lim)
                  && (17'(in_item.corner_c) < lim);
      idx_ok_r <= (32'(in_item.vertex_index) < MAX_VERTICES);
    end
  end

  assign ia   = item.corner_a[AW-1:0];
  assign ib   = item.corner_b[AW-1:0];
  assign ic   = item.corner_c[AW-1:0];
  assign vidx = AW'(item.vertex_index);

  assign stat.tri_ok = tri_ok_r;
  assign stat.idx_ok = idx_ok_r;

  assign pos_we = ctrl.wr_load && idx_ok_r;
  always_comb begin
    pos_raddr = ia;
    if (ctrl.rd_b) pos_raddr = ib;
    if (ctrl.rd_c) pos_raddr = ic;
  end

  vng_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos (
    .clk(clk), .we(pos_we), .waddr(vidx),
    .wdata({item.pos_x, item.pos_y, item.pos_z}),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  // edges from corner a
  always_ff @(posedge clk) begin
    if (ctrl.cap_a) begin
      pa[0] <= pos_rdata[47:32]; pa[1] <= pos_rdata[31:16]; pa[2] <= pos_rdata[15:0];
    end
    if (ctrl.cap_b) begin
      pb[0] <= pos_rdata[47:32]; pb[1] <= pos_rdata[31:16]; pb[2] <= pos_rdata[15:0];
    end
    if (ctrl.edge_en) begin
      e1[0] <= 17'(pb[0]) - 17'(pa[0]);
      e1[1] <= 17'(pb[1]) - 17'(pa[1]);
      e1[2] <= 17'(pb[2]) - 17'(pa[2]);
      e2[0] <= 17'(signed'(pos_rdata[47:32])) - 17'(pa[0]);
      e2[1] <= 17'(signed'(pos_rdata[31:16])) - 17'(pa[1]);
      e2[2] <= 17'(signed'(pos_rdata[15:0])) - 17'(pa[2]);
    end
    if (ctrl.mul_en) begin
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
    end
    if (ctrl.cross_en) begin
      nrm[0] <= 35'(pr[0]) - 35'(pr[1]);
      nrm[1] <= 35'(pr[2]) - 35'(pr[3]);
      nrm[2] <= 35'(pr[4]) - 35'(pr[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= '0;
    end else if (ctrl.acc_wr) begin
      corner <= (corner == 2'd2) ? 2'd0 : corner + 2'd1;
    end
  end

  always_comb begin
    acc_raddr = vidx;
    if (ctrl.acc_rd) begin
      case (corner)
        2'd0:    acc_raddr = ia;
        2'd1:    acc_raddr = ib;
        default: acc_raddr = ic;
      endcase
    end
  end

  // saturating 48-bit add
  always_comb begin
    logic signed [ACC_W:0] s;
    for (int k = 0; k < 3; k++) begin
      acc_old[k] = acc_rdata[ACC_W*(3-k)-1 -: ACC_W];
      s = (ACC_W+1)'(acc_old[k]) + (ACC_W+1)'(nrm[k]);
      if (s[ACC_W] != s[ACC_W-1]) begin
        acc_new[k] = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_new[k] = s[ACC_W-1:0];
      end
    end
  end

  always_comb begin
    acc_we    = pos_we || ctrl.acc_wr;
    acc_waddr = ctrl.acc_wr ? ((corner == 2'd0) ? ia : (corner == 2'd1) ? ib : ic) : vidx;
    acc_wdata = ctrl.acc_wr ? {acc_new[0], acc_new[1], acc_new[2]} : '0;
  end

  vng_ram #(.WIDTH(3*ACC_W), .DEPTH(MAX_VERTICES)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // ---- normalization ----
  logic [47:0] mag [3];
  logic        neg [3];
  logic        zero_r;
  logic [30:0] m [3];
  logic [61:0] sq [3];
  logic [63:0] ssum;
  logic [5:0]  bl;

  always_comb begin
    bl = '0;
    for (int i = 0; i < 48; i++) begin
      if (mag[0][i] || mag[1][i] || mag[2][i]) bl = 6'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.abs_en) begin
      for (int k = 0; k < 3; k++) begin
        neg[k] <= idx_ok_r && acc_old[k][ACC_W-1];
        mag[k] <= !idx_ok_r ? '0 :
                  acc_old[k][ACC_W-1] ? 48'(-acc_old[k]) : 48'(acc_old[k]);
      end
    end
    if (ctrl.shift_en) begin
      zero_r <= (bl == 6'd0);
      for (int k = 0; k < 3; k++) begin
        if (bl > 6'd31) m[k] <= 31'(mag[k] >> (bl - 6'd31));
        else            m[k] <= 31'(mag[k] << (6'd31 - bl));
      end
    end
    if (ctrl.sq_en) begin
      for (int k = 0; k < 3; k++) sq[k] <= 62'(m[k]) * 62'(m[k]);
    end
  end

  // bit-pair restoring square root, one result bit per cycle; the sum of
  // squares is loaded here and shifted out two bits per step
  logic [63:0] rem;
  logic [33:0] root;
  logic [5:0]  sq_cnt;
  logic        sq_busy, sq_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0; sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (ctrl.sum_en) begin
        ssum <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      end
      if (ctrl.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_cnt  <= 6'd32;
        rem     <= '0;
        root    <= '0;
      end else if (sq_busy) begin
        logic [65:0] trial;
        logic [65:0] r2;
        r2    = {rem, ssum[63:62]};
        trial = {root, 2'b01};
        ssum  <= ssum << 2;
        if (r2 >= trial) begin
          rem  <= 64'(r2 - trial);
          root <= {root[32:0], 1'b1};
        end else begin
          rem  <= 64'(r2);
          root <= {root[32:0], 1'b0};
        end
        sq_cnt <= sq_cnt - 6'd1;
        if (sq_cnt == 6'd1) begin
          sq_busy <= 1'b0; sq_done <= 1'b1;
        end
      end
    end
  end
  assign stat.sqrt_done = sq_done;

  // shared restoring divider: (m*16384 + r/2) / r, three components in turn
  logic [45:0] dnum;
  logic [45:0] dq;
  logic [33:0] drem;
  logic [5:0]  dcnt;
  logic [1:0]  dk;
  logic        dbusy, ddone;
  logic [15:0] q [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0; ddone <= 1'b0;
    end else begin
      ddone <= 1'b0;
      if (ctrl.div_start) begin
        dbusy <= 1'b1;
        dk    <= 2'd0;
        dcnt  <= 6'd46;
        drem  <= '0;
        dnum  <= {1'b0, m[0], 14'd0} + 46'(root >> 1);
      end else if (dbusy) begin
        logic [34:0] t;
        logic [45:0] qn;
        t  = {drem, dnum[45]};
        qn = {dq[44:0], 1'b0};
        if (t >= 35'(root)) begin
          t  = t - 35'(root);
          qn[0] = 1'b1;
        end
        dq <= qn;
        if (dcnt == 6'd1) begin
          q[dk] <= (qn > 46'(UNIT_Q14)) ? UNIT_Q14 : qn[15:0];
          if (dk == 2'd2) begin
            dbusy <= 1'b0; ddone <= 1'b1;
          end else begin
            dk   <= dk + 2'd1;
            dcnt <= 6'd46;
            drem <= '0;
            dnum <= {1'b0, m[dk + 2'd1], 14'd0} + 46'(root >> 1);
          end
        end else begin
          drem <= t[33:0];
          dnum <= dnum << 1;
          dcnt <= dcnt - 6'd1;
        end
      end
    end
  end
  assign stat.div_done = ddone;

  // output register
  assign stat.out_busy = out_valid && !out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_item.read_vertex   <= item.vertex_index;
      out_item.used_fallback <= zero_r;
      if (zero_r) begin
        out_item.normal_x <= '0;
        out_item.normal_y <= signed'(UNIT_Q14);
        out_item.normal_z <= '0;
      end else begin
        out_item.normal_x <= neg[0] ? -signed'(q[0]) : signed'(q[0]);
        out_item.normal_y <= neg[1] ? -signed'(q[1]) : signed'(q[1]);
        out_item.normal_z <= neg[2] ? -signed'(q[2]) : signed'(q[2]);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ctrl.div_start |-> !dbusy && !sq_busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> !stat.out_busy)
    else $error("output overwritten");
  assert property (@(posedge clk) disable iff (rst)
    sq_done |=> !sq_busy)
    else $error("sqrt still busy after done");
endmodule
